FILE: hdl/rbnh_pkg.sv
// Package for the 2D ray versus rotated box nearest-hit block.
// Holds payload structs, widths, the CORDIC arctangent table and controller commands.
package rbnh_pkg;

  localparam int COORD_BITS = 24;
  localparam int ANGLE_BITS = 16;
  localparam int DIST_BITS = 23;
  localparam int HALF_BITS = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_BITS = 4;
  localparam int DIV_BITS = 64;
  localparam int DIV_CNT_BITS = 7;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ray_origin_x;
    logic signed [COORD_BITS-1:0] ray_origin_z;
    logic [ANGLE_BITS-1:0]        ray_angle;
    logic [DIST_BITS-1:0]         ray_max_distance;
    logic signed [COORD_BITS-1:0] box_center_x;
    logic signed [COORD_BITS-1:0] box_center_z;
    logic [HALF_BITS-1:0]         box_half_length;
    logic [HALF_BITS-1:0]         box_half_width;
    logic [ANGLE_BITS-1:0]        box_angle;
    logic                         box_present;
    logic                         first_of_ray;
    logic                         last_of_ray;
  } in_item_t;

  typedef struct packed {
    logic                 any_hit;
    logic [DIST_BITS-1:0] nearest_distance;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CORDIC_BOX, CMD_CORDIC_REL, CMD_LOCAL,
    CMD_MUL2, CMD_AXIS_SETUP, CMD_DIV_START, CMD_DIV_STEP,
    CMD_DIV_TAKE, CMD_UPDATE, CMD_CLEAR
  } cmd_e;

  typedef struct packed {
    cmd_e           cmd;
    logic           axis;
    logic           which;
    logic [STEP_BITS-1:0] step;
  } ctl_t;

  typedef struct packed {
    logic parallel;
    logic par_miss;
    logic div_done;
  } sts_t;

  function automatic logic signed [31:0] atan_step(input logic [STEP_BITS-1:0] i);
    logic signed [31:0] r;
    unique case (i)
      4'd0: r = 32'sd536870912;  4'd1: r = 32'sd316933406;
      4'd2: r = 32'sd167458907;  4'd3: r = 32'sd85004756;
      4'd4: r = 32'sd42667331;   4'd5: r = 32'sd21354465;
      4'd6: r = 32'sd10679838;   4'd7: r = 32'sd5340245;
      4'd8: r = 32'sd2670163;    4'd9: r = 32'sd1335087;
      4'd10: r = 32'sd667544;    4'd11: r = 32'sd333772;
      4'd12: r = 32'sd166886;    4'd13: r = 32'sd83443;
      4'd14: r = 32'sd41722;     default: r = 32'sd20861;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/rbnh_divider.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on rbnh_pkg for widths.
module rbnh_divider (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [rbnh_pkg::DIV_BITS-1:0] num_i,
  input  logic signed [rbnh_pkg::DIV_BITS-1:0] den_i,
  output logic                                done_o,
  output logic signed [rbnh_pkg::DIV_BITS-1:0] quo_o
);
  import rbnh_pkg::*;

  logic [DIV_BITS-1:0]     rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic                    neg_q, neg_d, busy_q, busy_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic [DIV_BITS:0]       trial;
  logic [DIV_BITS-1:0]     sh_rem;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; neg_d = neg_q;
    busy_d = busy_q; cnt_d = cnt_q;
    sh_rem = {rem_q[DIV_BITS-2:0], quo_q[DIV_BITS-1]};
    trial = {1'b0, sh_rem} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i[DIV_BITS-1] ? DIV_BITS'(-num_i) : num_i;
      den_d = den_i[DIV_BITS-1] ? DIV_BITS'(-den_i) : den_i;
      neg_d = num_i[DIV_BITS-1] ^ den_i[DIV_BITS-1];
      busy_d = 1'b1;
      cnt_d = '0;
    end else if (busy_q) begin
      if (!trial[DIV_BITS]) begin
        rem_d = trial[DIV_BITS-1:0];
        quo_d = {quo_q[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_d = sh_rem;
        quo_d = {quo_q[DIV_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_BITS'(DIV_BITS-1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = !busy_q && !start_i;
  assign quo_o = neg_q ? DIV_BITS'(-quo_q) : quo_q;
endmodule

FILE: hdl/rbnh_datapath.sv
// Datapath: CORDIC sine/cosine, frame transform, slab distances and nearest-hit state.
// Depends on rbnh_pkg and rbnh_divider.
module rbnh_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rbnh_pkg::in_item_t item_i,
  input  rbnh_pkg::ctl_t     ctl_i,
  output rbnh_pkg::sts_t     sts_o,
  output rbnh_pkg::out_item_t res_o
);
  import rbnh_pkg::*;

  localparam int CW = 20;
  localparam int PW = 64;

  in_item_t            it_q;
  logic signed [CW-1:0] x_q, y_q, bc_q, bs_q, rc_q, rs_q;
  logic signed [31:0]  z_q;
  logic [1:0]          quad_q;
  logic                zero_q;
  logic signed [COORD_BITS:0] dx_q, dz_q;
  logic signed [PW-1:0] p_q, lo0_q, lo1_q, t1_q, tmin_q, tmax_q, num_q, den_q;
  logic [DIST_BITS-1:0] best_q;
  logic                 have_q, miss_q;
  logic                 div_start;
  logic                 div_done;
  logic signed [PW-1:0] quo;

  logic [31:0]          a32;
  logic signed [CW-1:0] xs, ys, xsat, ysat, cc, ss;
  logic signed [CW-1:0] mc, ms;
  logic signed [PW-1:0] lo_a, half_a, ld_a;
  logic signed [PW-1:0] lo, hf;
  logic signed [CW-1:0] ld;
  logic signed [COORD_BITS:0] mdx;
  logic signed [CW-1:0] mcs;
  logic signed [COORD_BITS+CW:0] mul_r;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] lo_t, hi_t;

  rbnh_divider u_div (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(div_start),
    .num_i(num_q), .den_i(den_q), .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    a32 = ctl_i.which ? 32'(it_q.ray_angle - it_q.box_angle) << (32 - ANGLE_BITS)
                      : 32'(it_q.box_angle) << (32 - ANGLE_BITS);
    xs = x_q >>> ctl_i.step;
    ys = y_q >>> ctl_i.step;
    xsat = (x_q > 20'sd65536) ? 20'sd65536 : (x_q < -20'sd65536) ? -20'sd65536 : x_q;
    ysat = (y_q > 20'sd65536) ? 20'sd65536 : (y_q < -20'sd65536) ? -20'sd65536 : y_q;
    if (zero_q) begin
      xsat = 20'sd65536; ysat = '0;
    end
    unique case (quad_q)
      2'd0: begin cc = xsat; ss = ysat; end
      2'd1: begin cc = -ysat; ss = xsat; end
      2'd2: begin cc = -xsat; ss = -ysat; end
      default: begin cc = ysat; ss = -xsat; end
    endcase
    // local transform: axis and step[0] select the partial product
    mdx = ctl_i.which ? dz_q : dx_q;
    mc = ctl_i.axis ? bc_q : bc_q;
    ms = bs_q;
    mcs = ctl_i.step[0] ? ms : mc;
    if (ctl_i.axis) begin
      mdx = ctl_i.step[0] ? dx_q : dz_q;
    end else begin
      mdx = ctl_i.step[0] ? dz_q : dx_q;
    end
    mul_r = mdx * mcs;
    prod = PW'(mul_r);
    lo = ctl_i.axis ? lo1_q : lo0_q;
    hf = ctl_i.axis ? PW'({it_q.box_half_width, 16'd0}) : PW'({it_q.box_half_length, 16'd0});
    ld = ctl_i.axis ? rs_q : rc_q;
    lo_a = lo; half_a = hf; ld_a = PW'(ld);
    lo_t = (t1_q < quo) ? t1_q : quo;
    hi_t = (t1_q < quo) ? quo : t1_q;
    sts_o.parallel = (ld == '0);
    sts_o.par_miss = (lo_a < -half_a) || (lo_a > half_a);
    sts_o.div_done = div_done;
    div_start = (ctl_i.cmd == CMD_DIV_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      have_q <= 1'b0;
    end else begin
      if (ctl_i.cmd == CMD_LOAD && item_i.first_of_ray) begin
        best_q <= '0; have_q <= 1'b0;
      end else if (ctl_i.cmd == CMD_UPDATE) begin
        if (!miss_q && (!have_q || tmin_q[DIST_BITS-1:0] < best_q)) begin
          best_q <= tmin_q[DIST_BITS-1:0]; have_q <= 1'b1;
        end
      end else if (ctl_i.cmd == CMD_CLEAR) begin
        best_q <= '0; have_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.cmd)
      CMD_LOAD: begin
        it_q <= item_i;
        dx_q <= (COORD_BITS+1)'(item_i.ray_origin_x) - (COORD_BITS+1)'(item_i.box_center_x);
        dz_q <= (COORD_BITS+1)'(item_i.ray_origin_z) - (COORD_BITS+1)'(item_i.box_center_z);
        tmin_q <= '0;
        tmax_q <= PW'(item_i.ray_max_distance);
        miss_q <= 1'b0;
      end
      CMD_CORDIC_BOX, CMD_CORDIC_REL: begin
        if (ctl_i.step == '0 && !ctl_i.axis) begin
          quad_q <= a32[31:30];
          zero_q <= (a32[29:0] == '0);
          z_q <= 32'({2'b00, a32[29:0]});
          x_q <= 20'sd39797;
          y_q <= '0;
        end else begin
          if (!z_q[31]) begin
            x_q <= x_q - ys; y_q <= y_q + xs; z_q <= z_q - atan_step(ctl_i.step);
          end else begin
            x_q <= x_q + ys; y_q <= y_q - xs; z_q <= z_q + atan_step(ctl_i.step);
          end
        end
      end
      CMD_LOCAL: begin
        if (ctl_i.which) begin rc_q <= cc; rs_q <= ss; end
        else begin bc_q <= cc; bs_q <= ss; end
      end
      CMD_MUL2: begin
        if (!ctl_i.step[0]) p_q <= prod;
        else if (!ctl_i.axis) lo0_q <= p_q + prod;
        else lo1_q <= p_q - prod;
      end
      CMD_AXIS_SETUP: begin
        if (sts_o.parallel && sts_o.par_miss) miss_q <= 1'b1;
        num_q <= ctl_i.which ? (half_a - lo_a) : (-half_a - lo_a);
        den_q <= ld_a;
      end
      CMD_DIV_TAKE: begin
        if (!ctl_i.which) t1_q <= quo;
        else begin
          if (lo_t > tmin_q && hi_t < tmax_q) begin
            tmin_q <= lo_t; tmax_q <= hi_t; miss_q <= miss_q || (lo_t > hi_t);
          end else if (lo_t > tmin_q) begin
            tmin_q <= lo_t; miss_q <= miss_q || (lo_t > tmax_q);
          end else if (hi_t < tmax_q) begin
            tmax_q <= hi_t; miss_q <= miss_q || (tmin_q > hi_t);
          end else miss_q <= miss_q || (tmin_q > tmax_q);
        end
      end
      default: ;
    endcase
  end

  assign res_o.any_hit = have_q;
  assign res_o.nearest_distance = have_q ? best_q : '0;
endmodule

FILE: hdl/rbnh_ctrl.sv
// Controller state machine sequencing CORDIC, transform, divisions and result output.
// Depends on rbnh_pkg.
module rbnh_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                box_present_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  rbnh_pkg::sts_t      sts_i,
  output rbnh_pkg::ctl_t      ctl_o,
  output logic                snap_o
);
  import rbnh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CB, S_CR, S_SC, S_MUL, S_SETUP, S_DSTART, S_DWAIT, S_TAKE,
    S_UPD, S_OUT
  } state_e;

  state_e               st_q;
  logic [STEP_BITS-1:0] step_q;
  logic                 axis_q, which_q, last_q, first_q, ov_q;
  logic                 emit;

  always_comb begin
    ctl_o = '{cmd: CMD_NONE, axis: axis_q, which: which_q, step: step_q};
    snap_o = 1'b0;
    in_stall_o = (st_q != S_IDLE);
    // result moves to the output register once it is free or being taken
    emit = (st_q == S_OUT) && last_q && (!ov_q || !out_stall_i);
    unique case (st_q)
      S_IDLE: if (in_valid_i && !in_stall_o) ctl_o.cmd = CMD_LOAD;
      S_CB: begin ctl_o.cmd = CMD_CORDIC_BOX; ctl_o.which = 1'b0; ctl_o.axis = first_q; end
      S_CR: begin ctl_o.cmd = CMD_CORDIC_REL; ctl_o.which = 1'b1; ctl_o.axis = first_q; end
      S_SC: ctl_o.cmd = CMD_LOCAL;
      S_MUL: ctl_o.cmd = CMD_MUL2;
      S_SETUP: ctl_o.cmd = CMD_AXIS_SETUP;
      S_DSTART: ctl_o.cmd = CMD_DIV_START;
      S_DWAIT: ctl_o.cmd = CMD_NONE;
      S_TAKE: ctl_o.cmd = CMD_DIV_TAKE;
      S_UPD: ctl_o.cmd = CMD_UPDATE;
      default: begin
        if (emit) begin
          ctl_o.cmd = CMD_CLEAR;
          snap_o = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; step_q <= '0; axis_q <= 1'b0; which_q <= 1'b0;
      last_q <= 1'b0; first_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (emit) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        S_IDLE: if (in_valid_i && !in_stall_o) begin
          last_q <= last_i;
          step_q <= '0; first_q <= 1'b0; axis_q <= 1'b0;
          st_q <= box_present_i ? S_CB : S_OUT;
        end
        S_CB, S_CR: begin
          // an initialization step first, then 16 rotation steps
          if (!first_q) first_q <= 1'b1;
          else if (step_q == STEP_BITS'(CORDIC_STEPS-1)) begin
            step_q <= '0; first_q <= 1'b0;
            st_q <= S_SC;
            which_q <= (st_q == S_CR);
          end else step_q <= step_q + 1'b1;
        end
        S_SC: begin
          if (!which_q) st_q <= S_CR;
          else begin st_q <= S_MUL; axis_q <= 1'b0; step_q <= '0; end
        end
        S_MUL: begin
          if (step_q[0] == 1'b0) step_q <= STEP_BITS'(1);
          else begin
            step_q <= '0;
            if (!axis_q) axis_q <= 1'b1;
            else begin axis_q <= 1'b0; which_q <= 1'b0; st_q <= S_SETUP; end
          end
        end
        S_SETUP: begin
          if (sts_i.parallel) begin
            if (sts_i.par_miss || axis_q) st_q <= S_UPD;
            else begin axis_q <= 1'b1; which_q <= 1'b0; end
          end else st_q <= S_DSTART;
        end
        S_DSTART: st_q <= S_DWAIT;
        S_DWAIT: if (sts_i.div_done) st_q <= S_TAKE;
        S_TAKE: begin
          if (!which_q) begin which_q <= 1'b1; st_q <= S_SETUP; end
          else if (axis_q) st_q <= S_UPD;
          else begin
            which_q <= 1'b0; axis_q <= 1'b1;
            st_q <= S_SETUP;
          end
        end
        S_UPD: st_q <= S_OUT;
        default: begin
          if (!last_q || emit) st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = ov_q;
endmodule

FILE: hdl/ray_box_nearest_hit_2d.sv
// Top level of the 2D ray versus rotated box nearest-hit block.
// Depends on rbnh_pkg, rbnh_ctrl, rbnh_datapath.
//
// Usage: one input transaction carries a ray and an optional box. The nearest
// entry distance across the items of one ray is kept; on the item flagged
// last_of_ray one output transaction carries any_hit and nearest_distance.
// Items are processed one at a time; in_stall_o is high while an item is in
// work. A box item runs two CORDIC passes (init, 16 rotations, store), four
// transform products, up to four divisions on the one shared 64-step divider
// (two per axis; a parallel axis skips both), then update and output. An
// empty item goes straight to the output step. The next item is accepted
// once the block is back in idle, so a new item is never taken while one is
// in work. out_valid_o rises from a register set in the output step of the
// last item of a ray. The result waits in an output register while
// out_stall_i is high; new items are still taken, but the next result holds
// the block in its output step until the register frees.
// Reset clears the controller, the pending result and the hit state.
module ray_box_nearest_hit_2d (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rbnh_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rbnh_pkg::out_item_t  out_data_o
);
  import rbnh_pkg::*;

  ctl_t      ctl;
  sts_t      sts;
  out_item_t res, res_q;
  logic      snap;

  rbnh_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .box_present_i(in_data_i.box_present), .last_i(in_data_i.last_of_ray),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .sts_i(sts),
    .ctl_o(ctl), .snap_o(snap)
  );

  rbnh_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .item_i(in_data_i), .ctl_i(ctl),
    .sts_o(sts), .res_o(res)
  );

  always_ff @(posedge clk_i) begin
    if (snap) res_q <= res;
  end

  assign out_data_o = res_q;
endmodule

FILE: dv/tb_ray_box_nearest_hit_2d.sv
// Testbench for ray_box_nearest_hit_2d: a directed table, then random ray queries,
// checked against a CORDIC and slab-test predictor. Depends on rbnh_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_ray_box_nearest_hit_2d;
  import rbnh_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  ray_box_nearest_hit_2d dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  localparam longint ATAN_TAB [16] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  out_item_t         pending_hits[$];
  logic [22:0]       best_dist;
  bit                have_hit;
  int                errors;
  int                n_items, n_results, n_hits;
  int                phase;
  bit                held;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void cordic_sin_cos(input logic [31:0] a, output longint c,
                                         output longint s);
    longint x, y, z, xs, ys;
    x = 39797;
    y = 0;
    z = longint'(a[29:0]);
    if (z == 0) begin
      x = 65536;
    end else begin
      for (int i = 0; i < 16; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= ATAN_TAB[i];
        end else begin
          x += ys; y -= xs; z += ATAN_TAB[i];
        end
      end
      x = (x > 65536) ? 65536 : (x < -65536) ? -65536 : x;
      y = (y > 65536) ? 65536 : (y < -65536) ? -65536 : y;
    end
    case (a[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic bit slab_entry(input in_item_t it, output logic [22:0] entry_dist);
    longint dx, dz, bc, bs, rc, rs, t1, t2, tt, tmin, tmax;
    longint lo [2], ld [2], half [2];
    logic [31:0] ra, ba;
    dx = longint'($signed(it.ray_origin_x)) - longint'($signed(it.box_center_x));
    dz = longint'($signed(it.ray_origin_z)) - longint'($signed(it.box_center_z));
    ra = {it.ray_angle, 16'h0};
    ba = {it.box_angle, 16'h0};
    cordic_sin_cos(ba, bc, bs);
    cordic_sin_cos(ra - ba, rc, rs);
    lo[0] = dx * bc + dz * bs;
    lo[1] = dz * bc - dx * bs;
    ld[0] = rc;
    ld[1] = rs;
    half[0] = longint'(it.box_half_length) * 65536;
    half[1] = longint'(it.box_half_width) * 65536;
    tmin = 0;
    tmax = longint'(it.ray_max_distance);
    entry_dist = '0;
    for (int ax = 0; ax < 2; ax++) begin
      if (ld[ax] == 0) begin
        if (lo[ax] < -half[ax] || lo[ax] > half[ax]) return 0;
        continue;
      end
      t1 = (-half[ax] - lo[ax]) / ld[ax];
      t2 = (half[ax] - lo[ax]) / ld[ax];
      if (t1 > t2) begin
        tt = t1; t1 = t2; t2 = tt;
      end
      if (t1 > tmin) tmin = t1;
      if (t2 < tmax) tmax = t2;
      if (tmin > tmax) return 0;
    end
    entry_dist = tmin[22:0];
    return 1;
  endfunction

  function automatic bit predict_nearest(input in_item_t it, output out_item_t res);
    logic [22:0] d;
    res = '0;
    if (it.first_of_ray) begin
      best_dist = '0; have_hit = 0;
    end
    if (it.box_present && slab_entry(it, d) && (!have_hit || d < best_dist)) begin
      best_dist = d; have_hit = 1;
    end
    if (it.last_of_ray) begin
      res.any_hit = have_hit;
      res.nearest_distance = have_hit ? best_dist : '0;
      best_dist = '0; have_hit = 0;
      return 1;
    end
    return 0;
  endfunction

  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    int idle_pct;
    idle_pct = (phase == 1) ? 54 : (phase == 3) ? 20 : 0;
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    n_items++;
    if (predict_nearest(it, res)) pending_hits.push_back(typed ? typed_res : res);
  endtask

  function automatic logic [23:0] near_coord(input int span);
    return 24'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic send_ray(input bit noisy);
    in_item_t it;
    int len;
    bit wide;
    len = $urandom_range(1, 5);
    wide = ($urandom_range(99) < 25);
    it = '0;
    it.ray_origin_x = wide ? 24'($urandom) : near_coord(200 << 8);
    it.ray_origin_z = wide ? 24'($urandom) : near_coord(200 << 8);
    it.ray_angle = 16'($urandom);
    it.ray_max_distance = ($urandom_range(3) == 0) ? 23'($urandom) :
                          23'($urandom_range(0, 600 << 8));
    for (int i = 0; i < len; i++) begin
      it.box_center_x = wide ? 24'($urandom) : near_coord(200 << 8);
      it.box_center_z = wide ? 24'($urandom) : near_coord(200 << 8);
      it.box_half_length = wide ? 16'($urandom) : 16'($urandom_range(0, 60 << 8));
      it.box_half_width = wide ? 16'($urandom) : 16'($urandom_range(0, 60 << 8));
      it.box_angle = ($urandom_range(7) == 0) ? 16'($urandom_range(3) << 14) : 16'($urandom);
      it.box_present = ($urandom_range(9) != 0);
      it.first_of_ray = (i == 0);
      it.last_of_ray = (i == len - 1);
      if (noisy) begin
        it.first_of_ray = 1'($urandom_range(1));
        it.last_of_ray = 1'($urandom_range(1));
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // out_stall_i ownership: random stalls per phase, plus one long hold-off
  initial begin
    int stall_pct;
    forever begin
      @(negedge clk_i);
      if (phase == 2 && !held) begin
        held = 1;
        out_stall_i <= 1'b1;
        repeat (3000) @(negedge clk_i);
      end
      stall_pct = (phase == 2) ? 54 : (phase == 3) ? 20 : 0;
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending_hits.size() == 0) begin
        report_mismatch("result with no transaction expected");
      end else begin
        exp_res = pending_hits.pop_front();
        if (out_data_o.any_hit) n_hits++;
        if (out_data_o.any_hit !== exp_res.any_hit)
          report_mismatch($sformatf("any_hit %b, expected %b",
                                    out_data_o.any_hit, exp_res.any_hit));
        if (out_data_o.nearest_distance !== exp_res.nearest_distance)
          report_mismatch($sformatf("nearest_distance %0d, expected %0d",
                                    out_data_o.nearest_distance,
                                    exp_res.nearest_distance));
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    int waited;
    best_dist = '0;
    have_hit = 0;
    phase = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty query
    r = '{item: '0, typed: 1, res: '0};
    r.item.first_of_ray = 1; r.item.last_of_ray = 1;
    rows.push_back(r);
    // origin inside the box: entry at zero
    r.item.box_present = 1;
    r.item.ray_max_distance = 23'(100 << 8);
    r.item.box_half_length = 16'(10 << 8); r.item.box_half_width = 16'(10 << 8);
    r.res = '{any_hit: 1'b1, nearest_distance: 23'd0};
    rows.push_back(r);
    // straight ahead, 40 units away, side axis parallel
    r.item.ray_origin_x = 24'(-(50 << 8));
    r.res = '{any_hit: 1'b1, nearest_distance: 23'(40 << 8)};
    rows.push_back(r);
    // same, max distance too short
    r.item.ray_max_distance = 23'(5 << 8);
    r.res = '0;
    rows.push_back(r);
    // extremes of every field
    r = '{item: '1, typed: 0, res: '0};
    rows.push_back(r);
    r.item.ray_origin_x = 24'h800000; r.item.ray_origin_z = 24'h800000;
    r.item.box_half_length = '0; r.item.box_half_width = '0;
    r.item.ray_angle = '0; r.item.box_angle = 16'h8000;
    rows.push_back(r);
    r.item.box_center_x = 24'h7fffff; r.item.box_center_z = 24'h800000;
    r.item.ray_angle = 16'h4000; r.item.box_angle = 16'hc000;
    rows.push_back(r);
    // multi-item ray: tie, closer box, empty item, late first_of_ray
    r = '{item: '0, typed: 0, res: '0};
    r.item.ray_origin_x = 24'(-(50 << 8));
    r.item.ray_max_distance = 23'h7fffff;
    r.item.box_half_length = 16'(10 << 8); r.item.box_half_width = 16'(10 << 8);
    r.item.box_present = 1; r.item.first_of_ray = 1;
    rows.push_back(r);
    r.item.first_of_ray = 0;
    rows.push_back(r);
    r.item.box_center_x = 24'(-(30 << 8)); r.item.box_angle = 16'h2000;
    rows.push_back(r);
    r.item.box_present = 0;
    rows.push_back(r);
    r.item.box_present = 1; r.item.box_center_x = 24'(40 << 8); r.item.ray_angle = 16'h8000;
    r.item.last_of_ray = 1;
    rows.push_back(r);
    r.item.last_of_ray = 0; r.item.ray_angle = 16'h0001;
    rows.push_back(r);
    r.item.first_of_ray = 1; r.item.last_of_ray = 1; r.item.ray_angle = 16'hffff;
    rows.push_back(r);

    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);

    for (int p = 0; p < 4; p++) begin
      int start;
      phase = p;
      start = n_items;
      while (n_items - start < 212) send_ray($urandom_range(9) == 0);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_hits.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (400) @(posedge clk_i);
    if (pending_hits.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_hits.size()));

    $display("Ran %0d input transactions, %0d results (%0d hits), under four",
             n_items, n_results, n_hits);
    $display("idle and stall patterns plus one long output hold-off.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: ray_box_nearest_hit_2d.f
hdl/rbnh_pkg.sv
hdl/rbnh_divider.sv
hdl/rbnh_datapath.sv
hdl/rbnh_ctrl.sv
hdl/ray_box_nearest_hit_2d.sv
dv/tb_ray_box_nearest_hit_2d.sv
